[rtl/core/sha512_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_pkg
// Types, constants and round functions of the SHA-512 hash engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

   typedef logic [63:0] word_type;

   typedef struct packed {
      word_type   digest_word;
      logic [2:0] word_index;
      logic       last_word;
   } rsp_type;

   typedef struct packed {
      word_type   data_word;
      logic [3:0] byte_count;
      logic       end_of_message;
   } req_type;

   localparam word_type PAD_MARKER = 64'h8000_0000_0000_0000;

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type h;
      case (idx)
         3'd0: h = 64'h6a09e667f3bcc908;
         3'd1: h = 64'hbb67ae8584caa73b;
         3'd2: h = 64'h3c6ef372fe94f82b;
         3'd3: h = 64'ha54ff53a5f1d36f1;
         3'd4: h = 64'h510e527fade682d1;
         3'd5: h = 64'h9b05688c2b3e6c1f;
         3'd6: h = 64'h1f83d9abfb41bd6b;
         default: h = 64'h5be0cd19137e2179;
      endcase
      return h;
   endfunction

   function automatic word_type round_k(input logic [6:0] t);
      word_type k;
      case (t)
         7'd0: k = 64'h428a2f98d728ae22;   7'd1: k = 64'h7137449123ef65cd;
         7'd2: k = 64'hb5c0fbcfec4d3b2f;   7'd3: k = 64'he9b5dba58189dbbc;
         7'd4: k = 64'h3956c25bf348b538;   7'd5: k = 64'h59f111f1b605d019;
         7'd6: k = 64'h923f82a4af194f9b;   7'd7: k = 64'hab1c5ed5da6d8118;
         7'd8: k = 64'hd807aa98a3030242;   7'd9: k = 64'h12835b0145706fbe;
         7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
         7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
         7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
         7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
         7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
         7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
         7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
         7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
         7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
         7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
         7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
         7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
         7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
         7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
         7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
         7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
         7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
         7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
         7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
         7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
         7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
         7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
         7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
         7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
         7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
         7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
         7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
         7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
         7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
         7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
         7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
         7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
         7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
         7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
         7'd78: k = 64'h5fcb6fab3ad6faec;  default: k = 64'h6c44198c4a475817;
      endcase
      return k;
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type sig1(input word_type x);
      return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

   function automatic word_type bsig0(input word_type x);
      return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type bsig1(input word_type x);
      return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

endpackage
`default_nettype wire

[rtl/core/sha512_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_req_if / sha512_rsp_if
// Valid/ready channels of the SHA-512 hash engine.
// ----------------------------------------------------------------------------
interface sha512_req_if;
   logic                 valid;
   logic                 ready;
   sha512_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sha512_rsp_if;
   logic                 valid;
   logic                 ready;
   sha512_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/sha512_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_core
// Block buffer and schedule in one 16-entry RAM, hash and working variables
// in registers. One round per cycle for t < 16; schedule word read ahead into rd_ff.
// ----------------------------------------------------------------------------
module sha512_core (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   sha512_req_if.sink                 req,
   sha512_rsp_if.source               rsp
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FILL, ST_PREP, ST_ROUND, ST_ADD, ST_OUT
   } state_type;

   state_type            state_ff;
   sha512_pkg::word_type hash_ff [8];
   sha512_pkg::word_type v_ff [8];
   sha512_pkg::word_type mem [16];
   sha512_pkg::word_type rd_ff;
   logic [63:0]          len_ff;
   logic [3:0]           pos_ff;
   logic [6:0]           t_ff;
   logic [3:0]           rd_addr;
   logic                 wr_en;
   logic [3:0]           wr_addr;
   sha512_pkg::word_type wr_data;
   // padding sequencer
   logic                 pad_ff;      // in padding phase
   logic                 mark_ff;     // marker word still owed
   logic [2:0]           oidx_ff;
   logic                 final_ff;    // length placed in this block
   // schedule window: w[t-15], w[t-7], then partial sum with w[t-2]
   sha512_pkg::word_type w15_ff, w7_ff, part_ff;
   logic [1:0]           ph_ff;

   // data: one schedule word is produced per round. To keep one RAM read per
   // cycle, each round for t >= 16 steps through the read phases of ph_ff.
   sha512_pkg::word_type wt, t1, t2, new_w, fill_word;
   logic [3:0]           n_bytes;

   always_comb begin
      n_bytes = (req.payload.byte_count > 4'd8) ? 4'd8 : req.payload.byte_count;
   end

   always_comb begin
      new_w = rd_ff + part_ff;
      wt = (t_ff < 7'd16) ? rd_ff : new_w;
      t1 = v_ff[7] + sha512_pkg::bsig1(v_ff[4]) +
           ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) +
           sha512_pkg::round_k(t_ff) + wt;
      t2 = sha512_pkg::bsig0(v_ff[0]) +
           ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // padding word for the current position
   always_comb begin
      if (mark_ff) fill_word = sha512_pkg::PAD_MARKER;
      else if (pos_ff == 4'd14) fill_word = {61'd0, len_ff[63:61]};
      else if (pos_ff == 4'd15 && final_ff) fill_word = {len_ff[60:0], 3'd0};
      else fill_word = '0;
   end

   logic [3:0] base;
   assign base = t_ff[3:0];

   always_comb begin
      rd_addr = base;
      case (ph_ff)
         2'd0: rd_addr = base + 4'd9;
         2'd1: rd_addr = base + 4'd14;
         2'd2: rd_addr = base;
         default: rd_addr = base + 4'd2;
      endcase
      if (state_ff == ST_PREP) rd_addr = 4'd0;
      else if (state_ff == ST_ROUND && t_ff < 7'd16)
         rd_addr = (t_ff == 7'd15) ? 4'd1 : base + 4'd1;
   end

   assign req.ready = (state_ff == ST_IDLE) && !reset;

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = req.payload.data_word;
      if (state_ff == ST_IDLE && req.valid) begin
         wr_en = 1'b1;
         if (req.payload.end_of_message && n_bytes != 4'd8) begin
            wr_data = (n_bytes == 4'd0) ? sha512_pkg::PAD_MARKER :
               ((req.payload.data_word & ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * n_bytes)))
                | (sha512_pkg::PAD_MARKER >> (8 * n_bytes)));
         end
      end else if (state_ff == ST_FILL) begin
         wr_en = 1'b1;
         wr_data = fill_word;
      end else if (state_ff == ST_ROUND && t_ff >= 7'd16 && ph_ff == 2'd3) begin
         wr_en = 1'b1;
         wr_addr = base;
         wr_data = new_w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff <= '0;
         pos_ff <= '0;
         pad_ff <= 1'b0;
         mark_ff <= 1'b0;
         final_ff <= 1'b0;
         oidx_ff <= '0;
         t_ff <= '0;
         ph_ff <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= sha512_pkg::init_hash(3'(i));
      end else begin
         case (state_ff)
            ST_IDLE: if (req.valid) begin
               pos_ff <= pos_ff + 4'd1;
               if (!req.payload.end_of_message) begin
                  len_ff <= len_ff + 64'd8;
                  if (pos_ff == 4'd15) state_ff <= ST_PREP;
               end else begin
                  len_ff <= len_ff + {60'd0, n_bytes};
                  pad_ff <= 1'b1;
                  mark_ff <= (n_bytes == 4'd8);
                  final_ff <= 1'b0;
                  state_ff <= (pos_ff == 4'd15) ? ST_PREP : ST_FILL;
               end
            end
            ST_FILL: begin
               pos_ff <= pos_ff + 4'd1;
               mark_ff <= 1'b0;
               if (pos_ff == 4'd14 && !mark_ff) final_ff <= 1'b1;
               if (pos_ff == 4'd15) state_ff <= ST_PREP;
            end
            ST_PREP: begin
               t_ff <= '0;
               ph_ff <= '0;
               for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[i];
               state_ff <= ST_ROUND;
            end
            ST_ROUND: begin
               if (t_ff < 7'd16 || ph_ff == 2'd3) begin
                  v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
                  v_ff[4] <= v_ff[3] + t1;
                  v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
                  v_ff[0] <= t1 + t2;
                  t_ff <= t_ff + 7'd1;
                  ph_ff <= '0;
                  if (t_ff == 7'd79) state_ff <= ST_ADD;
               end else begin
                  ph_ff <= ph_ff + 2'd1;
                  case (ph_ff)
                     2'd0: w15_ff <= rd_ff;
                     2'd1: w7_ff <= rd_ff;
                     default: part_ff <= sha512_pkg::sig0(w15_ff) + w7_ff +
                                         sha512_pkg::sig1(rd_ff);
                  endcase
               end
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + v_ff[i];
               if (!pad_ff) state_ff <= ST_IDLE;
               else if (final_ff) begin
                  oidx_ff <= '0;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_FILL;
               end
            end
            ST_OUT: if (rsp.ready) begin
               oidx_ff <= oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++)
                     hash_ff[i] <= sha512_pkg::init_hash(3'(i));
                  len_ff <= '0;
                  pos_ff <= '0;
                  pad_ff <= 1'b0;
                  final_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.payload.digest_word = hash_ff[oidx_ff];
   assign rsp.payload.word_index = oidx_ff;
   assign rsp.payload.last_word = (oidx_ff == 3'd7);

endmodule
`default_nettype wire

[rtl/core/sha512_hash_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha512_hash_engine
// SHA-512 engine over a stream of 64-bit big-endian message words.
// ----------------------------------------------------------------------------
// One word is taken per cycle into a 16-entry block RAM while the engine is
// idle; the sixteenth word starts a compression: a prepare state, 16 rounds
// that take their words straight from the RAM, 64 rounds that each first
// fetch their schedule words through the single RAM read port, and an add
// state. The last word adds a fill step per remaining block slot, a second
// block when the length does not fit, and eight digest words on the response
// channel, one per cycle while rsp ready is high. No input is taken until the
// digest has gone out.
module sha512_hash_engine (
   input  wire  logic    clock,
   input  wire  logic    reset,
   sha512_req_if.sink    req,
   sha512_rsp_if.source  rsp
);

   sha512_core u_core (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

endmodule
`default_nettype wire

[tb/sha512_tb_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha512_tb_if
// Testbench helper package for the hash engine bench.
// ----------------------------------------------------------------------------
// The engine's own channel interfaces are used directly; this file only
// holds the helper that converts a message byte count to a word mask.
package sha512_tb_util;
   function automatic logic [63:0] lead_mask(input int unsigned nbytes);
      return (nbytes == 0) ? 64'h0 : ~64'h0 << (64 - 8 * nbytes);
   endfunction
endpackage

[tb/sha512_hash_engine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha512_hash_engine_tb
// Self-checking bench for the SHA-512 hash engine.
// ----------------------------------------------------------------------------
// Message words are driven, in the middle phases with random gaps and
// random digest stalls. A software SHA-512 digests each accepted word and the
// scoreboard compares every digest word, index and last flag in order.
module sha512_hash_engine_tb;

   class digest_board;
      sha512_pkg::word_type   hash_state[8];
      sha512_pkg::word_type   blk[16];
      logic [63:0] msg_bytes;
      int unsigned slot;
      sha512_pkg::rsp_type    pending[$];
      int         errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) hash_state[i] = sha512_pkg::init_hash(i[2:0]);
         msg_bytes = 0;
         slot = 0;
      endfunction

      function void compress_block();
         sha512_pkg::word_type w[80];
         sha512_pkg::word_type v[8];
         sha512_pkg::word_type t1, t2, ch, mj;
         for (int t = 0; t < 16; t++) w[t] = blk[t];
         for (int t = 16; t < 80; t++)
            w[t] = w[t-16] + sha512_pkg::sig0(w[t-15]) + w[t-7] + sha512_pkg::sig1(w[t-2]);
         for (int i = 0; i < 8; i++) v[i] = hash_state[i];
         for (int t = 0; t < 80; t++) begin
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t1 = v[7] + sha512_pkg::bsig1(v[4]) + ch + sha512_pkg::round_k(t[6:0]) + w[t];
            t2 = sha512_pkg::bsig0(v[0]) + mj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) hash_state[i] += v[i];
      endfunction

      function void push_word(sha512_pkg::word_type w);
         blk[slot] = w;
         slot = (slot + 1) % 16;
         if (slot == 0) compress_block();
      endfunction

      function void note_word(sha512_pkg::req_type r);
         int unsigned n;
         sha512_pkg::rsp_type e;
         if (!r.end_of_message) begin
            msg_bytes += 8;
            push_word(r.data_word);
            return;
         end
         n = (r.byte_count > 8) ? 8 : r.byte_count;
         msg_bytes += n;
         if (n == 8) begin
            push_word(r.data_word);
            push_word(sha512_pkg::PAD_MARKER);
         end else
            push_word((r.data_word & sha512_tb_util::lead_mask(n)) |
                      (sha512_pkg::PAD_MARKER >> (8 * n)));
         if (slot == 15) push_word('0);
         while (slot < 14) push_word('0);
         push_word(msg_bytes >> 61);
         push_word(msg_bytes << 3);
         for (int k = 0; k < 8; k++) begin
            e.digest_word = hash_state[k];
            e.word_index = k[2:0];
            e.last_word = (k == 7);
            pending.push_back(e);
         end
         restart();
      endfunction

      function void check_word(sha512_pkg::rsp_type got);
         sha512_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected digest word %h", $realtime, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.digest_word !== e.digest_word) begin
            $display("%0t digest_word exp %h got %h", $realtime, e.digest_word, got.digest_word);
            errors++;
         end
         if (got.word_index !== e.word_index) begin
            $display("%0t word_index exp %0d got %0d", $realtime, e.word_index, got.word_index);
            errors++;
         end
         if (got.last_word !== e.last_word) begin
            $display("%0t last_word exp %0d got %0d", $realtime, e.last_word, got.last_word);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   sha512_req_if req();
   sha512_rsp_if rsp();
   digest_board board;
   int send_gap, recv_stall;

   sha512_hash_engine uut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) board.note_word(req.payload);
         if (rsp.valid && rsp.ready) board.check_word(rsp.payload);
      end
   end

   always @(negedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_stall);
   end

   task automatic send_word(sha512_pkg::word_type d, logic [3:0] n, logic eom);
      while ($urandom_range(99) < send_gap) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= {d, n, eom};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_msg(int unsigned full_words, logic [3:0] n);
      sha512_pkg::word_type d;
      for (int i = 0; i < full_words; i++) begin
         d = {$urandom, $urandom};
         send_word(d, 4'($urandom_range(15)), 1'b0);
      end
      d = {$urandom, $urandom};
      send_word(d, n, 1'b1);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic random_msgs(int unsigned words);
      int unsigned sent, len;
      sent = 0;
      while (sent < words) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(16);
         send_msg(len, 4'($urandom_range(15)));
         sent += len + 1;
      end
   endtask

   initial begin
      board = new();
      reset = 1;
      req.valid = 0;
      req.payload = '0;
      rsp.ready = 0;
      send_gap = 0;
      recv_stall = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      send_word(64'h0, 4'd0, 1'b1);
      send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1);
      send_word(64'h6162_6300_0000_0000, 4'd3, 1'b1);
      send_word(64'hffff_ffff_ffff_ffff, 4'd15, 1'b1);
      send_word(64'h0123_4567_89ab_cdef, 4'd7, 1'b1);
      send_msg(13, 4'd7);
      send_msg(13, 4'd8);
      send_msg(14, 4'd0);
      send_msg(15, 4'd8);
      send_msg(15, 4'd3);
      drain();

      send_gap = 21; recv_stall = 53;
      random_msgs(55);
      drain();
      send_gap = 53; recv_stall = 21;
      random_msgs(55);
      drain();
      send_gap = 0; recv_stall = 0;
      random_msgs(40);
      drain();

      if (board.errors == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
